// ----- rtl/depth_sorted_draw_queue_macros.svh -----
// Assertion macros shared by the depth-sorted draw queue RTL.
// Depends on nothing; included by depth_sorted_draw_queue, the module that carries the assertions.
`ifndef DEPTH_SORTED_DRAW_QUEUE_MACROS_SVH
`define DEPTH_SORTED_DRAW_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dsdq_pkg.sv -----
// Types and codes shared by the depth-sorted draw queue.
// Used by dsdq_cell and depth_sorted_draw_queue; depends on nothing.
package dsdq_pkg;

    localparam int HandleWidth = 16;
    localparam int DepthWidth  = 16;

    // Action codes carried on the input tuser.
    localparam logic ACTION_INSERT = 1'b0;
    localparam logic ACTION_DRAIN  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_DRAINED  = 2'd2,
        KIND_EMPTY    = 2'd3
    } result_kind_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    // One stored entry of the list.
    typedef struct packed {
        logic                         valid;
        logic [HandleWidth-1:0]       handle;
        logic signed [DepthWidth-1:0] depth;
    } entry_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic insert;   // place the new entry, shifting larger depths up
        logic shift;    // move every entry one cell towards the head
    } cell_ctrl_t;

endpackage

// ----- rtl/dsdq_cell.sv -----
// One cell of the sorted row: holds a single entry and trades it with its neighbours.
// Depends on dsdq_pkg.
module dsdq_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dsdq_pkg::cell_ctrl_t ctrl,
    input  dsdq_pkg::entry_t     new_entry,   // entry being inserted
    input  dsdq_pkg::entry_t     left_entry,  // neighbour nearer the head
    input  logic                 left_place,  // new entry belongs at or before the left cell
    input  dsdq_pkg::entry_t     right_entry, // neighbour nearer the tail
    output dsdq_pkg::entry_t     cur_entry,
    output logic                 place
);
    import dsdq_pkg::*;

    logic                         valid_reg;
    logic                         valid_next;
    logic [HandleWidth-1:0]       handle_reg;
    logic [HandleWidth-1:0]       handle_next;
    logic signed [DepthWidth-1:0] depth_reg;
    logic signed [DepthWidth-1:0] depth_next;

    // The new entry goes here or earlier when this cell is empty or holds a deeper sprite.
    assign place = !valid_reg || ($signed(depth_reg) > $signed(new_entry.depth));

    assign cur_entry.valid  = valid_reg;
    assign cur_entry.handle = handle_reg;
    assign cur_entry.depth  = depth_reg;

    // Choose what the cell holds next: keep, take the left neighbour, the new entry or the right one.
    always_comb begin
        valid_next  = valid_reg;
        handle_next = handle_reg;
        depth_next  = depth_reg;
        if (ctrl.shift) begin
            valid_next  = right_entry.valid;
            handle_next = right_entry.handle;
            depth_next  = right_entry.depth;
        end else if (ctrl.insert && place) begin
            if (left_place) begin
                valid_next  = left_entry.valid;
                handle_next = left_entry.handle;
                depth_next  = left_entry.depth;
            end else begin
                valid_next  = 1'b1;
                handle_next = new_entry.handle;
                depth_next  = new_entry.depth;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        handle_reg <= handle_next;
        depth_reg  <= depth_next;
    end

endmodule

// ----- rtl/depth_sorted_draw_queue.sv -----
// Top level of the depth-sorted draw queue: a row of compare-and-shift cells and an output register.
// Depends on dsdq_pkg, dsdq_cell and depth_sorted_draw_queue_macros.svh.
//
//  Channel | Ports                  | tdata (low bit up)         | tuser        | tlast
//  --------+------------------------+----------------------------+--------------+--------
//  input   | s_tvalid/tready/data   | sprite_handle, depth_key   | action       | -
//  result  | m_tvalid/tready/data   | drawn_handle, drawn_depth  | result_kind  | is_last
//
// On an insert every cell compares its depth with the new key in parallel and the row shifts
// up behind the insertion point, so inserts run at one per cycle while the result channel
// keeps up.
// On a drain the row shifts one cell towards the head per result, and the output register
// takes one entry per cycle while the result channel accepts.
// Reset empties the list at once; entry payloads are not cleared.
// A stalled result channel holds the output register and stops both acceptance and draining.
module depth_sorted_draw_queue #(
    parameter int CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] sprite_handle, [31:16] depth_key
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] drawn_handle, [31:16] drawn_depth
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast    // is_last
);
    import dsdq_pkg::*;

    `include "depth_sorted_draw_queue_macros.svh"

    state_t       state_reg;
    state_t       state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_kind_t out_kind_reg;
    result_kind_t out_kind_next;
    entry_t       out_entry_reg;
    entry_t       out_entry_next;
    logic         out_last_reg;
    logic         out_last_next;

    entry_t              entries [CAPACITY];
    logic [CAPACITY-1:0] place_vec;
    logic [CAPACITY-1:0] valid_vec;
    entry_t              new_entry;
    cell_ctrl_t          ctrl;
    logic                out_free;
    logic                in_xfer;
    logic                full;

    assign new_entry.valid  = 1'b1;
    assign new_entry.handle = s_tdata[15:0];
    assign new_entry.depth  = $signed(s_tdata[31:16]);

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_xfer  = s_tvalid && s_tready;
    assign full     = valid_vec[CAPACITY-1];

    // Row of cells; the head cell is index 0.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_p;

        if (i == 0) begin : g_head
            assign left_e = '0;
            assign left_p = 1'b0;
        end else begin : g_mid
            assign left_e = entries[i-1];
            assign left_p = place_vec[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_body
            assign right_e = entries[i+1];
        end

        dsdq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_place  (left_p),
            .right_entry (right_e),
            .cur_entry   (entries[i]),
            .place       (place_vec[i])
        );

        assign valid_vec[i] = entries[i].valid;
    end

    // Sequencer: decides the row command and loads the output register.
    always_comb begin
        state_next     = state_reg;
        ctrl           = '0;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_entry_next = out_entry_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    out_valid_next = 1'b1;
                    out_entry_next = '0;
                    out_last_next  = 1'b1;
                    if (s_tuser == ACTION_INSERT) begin
                        if (full) begin
                            out_kind_next = KIND_REJECTED;
                        end else begin
                            out_kind_next = KIND_ACCEPTED;
                            ctrl.insert   = 1'b1;
                        end
                    end else if (!valid_vec[0]) begin
                        out_kind_next = KIND_EMPTY;
                    end else begin
                        out_kind_next  = KIND_DRAINED;
                        out_entry_next = entries[0];
                        out_last_next  = !valid_vec[1];
                        ctrl.shift     = 1'b1;
                        if (valid_vec[1]) begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DRAINED;
                    out_entry_next = entries[0];
                    out_last_next  = !valid_vec[1];
                    ctrl.shift     = 1'b1;
                    if (!valid_vec[1]) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg  <= out_kind_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tuser         = out_kind_reg;
    assign m_tdata[15:0]   = out_entry_reg.handle;
    assign m_tdata[31:16]  = out_entry_reg.depth;
    assign m_tlast         = out_last_reg;

    // The row stays packed towards the head.
    `DSDQ_ASSERT_NOW(a_row_packed, aclk, aresetn, 1'b1,
        ((valid_vec >> 1) & ~valid_vec) == '0, "gap in the cell row")
    // A drain in progress always has an entry at the head.
    `DSDQ_ASSERT_NOW(a_drain_nonempty, aclk, aresetn, state_reg == ST_DRAIN,
        valid_vec[0], "drain running on an empty row")
    // A rejected insert leaves the row untouched.
    `DSDQ_ASSERT_NEXT(a_reject_stable, aclk, aresetn,
        in_xfer && s_tuser == ACTION_INSERT && full,
        $stable(valid_vec), "rejected insert changed the row")
    // Only drained entries may be followed by more results of the same item.
    `DSDQ_ASSERT_NOW(a_single_last, aclk, aresetn,
        m_tvalid && m_tuser != KIND_DRAINED, m_tlast, "single result not marked last")
    // An accepted insert adds exactly one entry.
    `DSDQ_ASSERT_NEXT(a_insert_grows, aclk, aresetn,
        in_xfer && s_tuser == ACTION_INSERT && !full,
        $countones(valid_vec) == $countones($past(valid_vec)) + 1,
        "insert did not add one entry")

endmodule

// ----- test/dsdq_draw_list_scoreboard.sv -----
// Scoreboard for the depth-sorted draw queue: a depth-ordered list predictor and result checker.
// Depends on dsdq_pkg for the action and result kind codes.
`timescale 1ns / 1ps

package dsdq_tb_pkg;

    import dsdq_pkg::*;

    // One sprite held in the predicted draw list.
    typedef struct {
        logic [15:0]        handle;
        logic signed [15:0] depth;
    } sprite_t;

    // One result transfer the block owes us.
    typedef struct {
        result_kind_t       kind;
        logic [15:0]        handle;
        logic signed [15:0] depth;
        logic               last;
    } draw_result_t;

    class draw_list_scoreboard;

        int           capacity;
        sprite_t      draw_list[$];
        draw_result_t awaited[$];
        int           errors;
        int           results_checked;
        int           inserts_accepted;
        int           inserts_rejected;
        int           entries_drained;
        int           empty_drains;

        function new(int cap);
            capacity = cap;
            errors = 0;
            results_checked = 0;
            inserts_accepted = 0;
            inserts_rejected = 0;
            entries_drained = 0;
            empty_drains = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void await_result(result_kind_t kind, logic [15:0] handle,
                                   logic signed [15:0] depth, logic last);
            draw_result_t r;
            r.kind = kind;
            r.handle = handle;
            r.depth = depth;
            r.last = last;
            awaited.push_back(r);
        endfunction

        // Every mismatch prints one line and is counted.
        task report_mismatch(string what);
            errors++;
            $display("%0t ns: draw queue mismatch: %s", $time, what);
        endtask

        // Update the predicted list for one accepted input transfer and queue its results.
        function void note_input(logic action, logic [15:0] handle, logic signed [15:0] depth);
            sprite_t s;
            int      pos;
            if (action == ACTION_INSERT) begin
                if (draw_list.size() >= capacity) begin
                    await_result(KIND_REJECTED, '0, '0, 1'b1);
                    inserts_rejected++;
                end else begin
                    // Equal depths go behind the ones already stored, keeping arrival order.
                    pos = 0;
                    while (pos < draw_list.size() && draw_list[pos].depth <= depth)
                        pos++;
                    s.handle = handle;
                    s.depth = depth;
                    draw_list.insert(pos, s);
                    await_result(KIND_ACCEPTED, '0, '0, 1'b1);
                    inserts_accepted++;
                end
            end else if (draw_list.size() == 0) begin
                await_result(KIND_EMPTY, '0, '0, 1'b1);
                empty_drains++;
            end else begin
                foreach (draw_list[i])
                    await_result(KIND_DRAINED, draw_list[i].handle, draw_list[i].depth,
                                 i == draw_list.size() - 1);
                entries_drained += draw_list.size();
                draw_list.delete();
            end
        endfunction

        // Compare one result transfer with the oldest one owed.
        task check_result(logic [1:0] kind, logic [15:0] handle, logic signed [15:0] depth,
                          logic last);
            draw_result_t want;
            results_checked++;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result kind %0d arrived with nothing owed", kind));
            end else begin
                want = awaited.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, wanted %s", kind, want.kind.name()));
                if (handle !== want.handle)
                    report_mismatch($sformatf("handle %h, wanted %h", handle, want.handle));
                if (depth !== want.depth)
                    report_mismatch($sformatf("depth %0d, wanted %0d", depth, want.depth));
                if (last !== want.last)
                    report_mismatch($sformatf("tlast %b, wanted %b", last, want.last));
            end
        endtask

    endclass

endpackage

// ----- test/testbench.sv -----
// Self-checking testbench for depth_sorted_draw_queue: directed and random insert/drain traffic.
// Depends on dsdq_pkg, dsdq_tb_pkg and the depth_sorted_draw_queue RTL.
`timescale 1ns / 1ps

module testbench;

    import dsdq_pkg::*;
    import dsdq_tb_pkg::*;

    localparam int Capacity    = 32;
    localparam int RandomItems = 165;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] sprite_handle, [31:16] depth_key
    logic        s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [15:0] drawn_handle, [31:16] drawn_depth
    logic [1:0]  m_tuser;   // [1:0] result_kind
    logic        m_tlast;   // is_last

    draw_list_scoreboard sb;
    int                  items_sent;
    logic                steady_send;

    depth_sorted_draw_queue #(
        .CAPACITY(Capacity)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit, well beyond the slowest correct run.
    initial begin
        #5ms;
        $display("Timed out waiting for the draw queue.");
        $display("depth_sorted_draw_queue regression: fail");
        $finish;
    end

    // Result side: random back-pressure, with a stretch of steady acceptance.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sb != null && sb.results_checked >= 60 && sb.results_checked < 130)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 35);
        end
    end

    // Check every result transfer as it is accepted.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast);
    end

    // Offer one item on the input channel and wait for its transfer.
    task automatic send_item(logic action, logic [15:0] handle, logic [15:0] depth);
        @(negedge aclk);
        while (!steady_send && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {depth, handle};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_input(action, handle, depth);
        items_sent++;
        steady_send = (items_sent >= 90 && items_sent < 130);
    endtask

    // Depth keys drawn from the whole range, a narrow band full of ties, or the extremes.
    function automatic logic [15:0] pick_depth(int spread);
        logic [15:0] d;
        case (spread)
            0: d = 16'($urandom);
            1: d = 16'($urandom_range(0, 6) - 3);
            default: begin
                case ($urandom_range(0, 3))
                    0: d = 16'h8000;
                    1: d = 16'h7FFF;
                    2: d = 16'hFFFF;
                    default: d = 16'h0000;
                endcase
            end
        endcase
        return d;
    endfunction

    // Directed items: empty drains, extreme keys and handles, ties and ignored drain fields.
    task automatic run_directed();
        send_item(ACTION_DRAIN,  16'h0000, 16'h0000);
        send_item(ACTION_INSERT, 16'hFFFF, 16'h7FFF);
        send_item(ACTION_INSERT, 16'h0000, 16'h8000);
        send_item(ACTION_INSERT, 16'h1234, 16'h0000);
        send_item(ACTION_INSERT, 16'hA5A5, 16'h0000);
        send_item(ACTION_INSERT, 16'h5A5A, 16'h0000);
        send_item(ACTION_INSERT, 16'h8001, 16'hFFFF);
        send_item(ACTION_INSERT, 16'h0001, 16'h0001);
        send_item(ACTION_INSERT, 16'h7FFE, 16'h8000);
        send_item(ACTION_INSERT, 16'hC3C3, 16'h7FFF);
        send_item(ACTION_DRAIN,  16'hFFFF, 16'hFFFF);
        send_item(ACTION_DRAIN,  16'hBEEF, 16'h7FFF);
        send_item(ACTION_INSERT, 16'h0000, 16'h0000);
        send_item(ACTION_DRAIN,  16'h0000, 16'h8000);
    endtask

    // Random part: bursts of inserts closed by a drain, the first one longer than the list's capacity.
    task automatic run_random(int count);
        int stop_at;
        int burst;
        int spread;
        stop_at = items_sent + count;
        burst = Capacity + 3;
        spread = 1;
        while (items_sent < stop_at) begin
            repeat (burst) begin
                // A stray drain now and then breaks a burst in two.
                if ($urandom_range(0, 99) < 6)
                    send_item(ACTION_DRAIN, 16'($urandom), 16'($urandom));
                else
                    send_item(ACTION_INSERT, 16'($urandom), pick_depth(spread));
            end
            send_item(ACTION_DRAIN, 16'($urandom), 16'($urandom));
            if ($urandom_range(0, 9) == 0)
                send_item(ACTION_DRAIN, 16'($urandom), 16'($urandom));
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(Capacity - 2, Capacity + 4)
                                                : $urandom_range(0, 10);
            spread = $urandom_range(0, 2);
        end
    endtask

    // Main sequence: reset, stimulus, drain of outstanding results, verdict.
    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACTION_INSERT;
        items_sent  = 0;
        steady_send = 1'b0;
        sb = new(Capacity);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_random(RandomItems);
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (Capacity + 16) @(posedge aclk);

        $display("Covered %0d input transfers and %0d result transfers.",
                 items_sent, sb.results_checked);
        $display("Inserts accepted %0d, refused on a full list %0d;",
                 sb.inserts_accepted, sb.inserts_rejected);
        $display("%0d entries drained, %0d empty drains.",
                 sb.entries_drained, sb.empty_drains);
        if (sb.errors == 0) begin
            $display("depth_sorted_draw_queue regression: pass");
        end else begin
            $display("depth_sorted_draw_queue regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/dsdq_pkg.sv
rtl/dsdq_cell.sv
rtl/depth_sorted_draw_queue.sv
test/dsdq_draw_list_scoreboard.sv
test/testbench.sv
